// ----- rtl/core/dqne_pkg.sv -----
// Package for the DNS query name encoder.
// Holds sizes, register indexes, reset values and packet constants.
// No dependencies; compile first.
package dqne_pkg;

    localparam int LABEL_MAX = 32;
    localparam int CNT_W     = 6;
    localparam int ADDR_W    = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QTYPE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QCLASS       = 2'd3;

    localparam logic [15:0] RST_QUERY_ID     = 16'h5D3F;
    localparam logic [15:0] RST_HEADER_FLAGS = 16'h0100;
    localparam logic [15:0] RST_QTYPE        = 16'd16;
    localparam logic [15:0] RST_QCLASS       = 16'd1;

    localparam logic [7:0] DOT_CHAR = 8'h2E;

    // Header byte positions, 12 bytes in all.
    localparam logic [3:0] HDR_ID_HI    = 4'd0;
    localparam logic [3:0] HDR_ID_LO    = 4'd1;
    localparam logic [3:0] HDR_FLAGS_HI = 4'd2;
    localparam logic [3:0] HDR_FLAGS_LO = 4'd3;
    localparam logic [3:0] HDR_QDCNT_LO = 4'd5;
    localparam logic [3:0] HDR_LAST     = 4'd11;

    // Trailer byte positions after the last label.
    localparam logic [2:0] TL_ZERO     = 3'd0;
    localparam logic [2:0] TL_TYPE_HI  = 3'd1;
    localparam logic [2:0] TL_TYPE_LO  = 3'd2;
    localparam logic [2:0] TL_CLASS_HI = 3'd3;
    localparam logic [2:0] TL_CLASS_LO = 3'd4;

endpackage

// ----- rtl/core/dqne_in_if.sv -----
// Input channel of the DNS query name encoder: one name character per word.
// Depends on nothing.
interface dqne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       end_of_name;

    modport source (output valid, output name_char, output end_of_name, input ready);
    modport sink   (input valid, input name_char, input end_of_name, output ready);
endinterface

// ----- rtl/core/dqne_out_if.sv -----
// Output channel of the DNS query name encoder: one packet byte per word.
// Depends on nothing.
interface dqne_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       label_truncated;

    modport source (output valid, output packet_byte, output last_byte,
                    output label_truncated, input ready);
    modport sink   (input valid, input packet_byte, input last_byte,
                    input label_truncated, output ready);
endinterface

// ----- rtl/core/dqne_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds when no read is issued. No dependencies.
module dqne_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/dns_query_name_encoder.sv -----
// DNS query name encoder, top level. Uses dqne_pkg, dqne_in_if, dqne_out_if
// and dqne_ram.
//
// Feed a dotted name one character per word and finish it with a word that
// has end_of_name set; the block streams out a DNS query packet one byte per
// word. The first word of a name produces the 12-byte header (query_id,
// header_flags, question count 1, three zero counts). Each '.' or the end
// word closes a label, sent as its length byte and its characters; the end
// word then adds a zero byte, the query type word and the query class word,
// with last_byte set on the final class byte. Characters past LABEL_MAX are
// dropped and the label's bytes carry label_truncated. A plain character
// is written straight into the label RAM when it is accepted; if it is
// the first word of a name, the 12 header bytes go out before the next
// word is taken. A closing word emits 12 header bytes if it starts a name,
// the length byte and the label's characters, and 5 trailer bytes if it
// ends the name. The output register sends one byte per cycle while the
// receiver holds ready high and stalls while it holds ready low; the
// single read port of the label RAM is read one entry ahead of the output.
// Input is not taken while bytes are being emitted. Write configuration
// only while the block is idle.
module dns_query_name_encoder (
    input  logic                               clk,
    input  logic                               rst_n,
    dqne_in_if.sink                            name_in,
    dqne_out_if.source                         pkt_out,
    input  logic                               cfg_we,
    input  logic [dqne_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dqne_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import dqne_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_LEN,
        ST_DATA,
        ST_TAIL
    } state_t;

    // Configuration registers.
    logic [15:0] query_id_reg;
    logic [15:0] header_flags_reg;
    logic [15:0] qtype_reg;
    logic [15:0] qclass_reg;

    // Sequencer state.
    state_t           state_reg,    state_next;
    logic [3:0]       hdr_idx_reg,  hdr_idx_next;
    logic [2:0]       tail_idx_reg, tail_idx_next;
    logic [CNT_W-1:0] rd_idx_reg,   rd_idx_next;
    logic [CNT_W-1:0] count_reg,    count_next;
    logic             overflow_reg, overflow_next;
    logic             started_reg,  started_next;
    logic             pend_close_reg, pend_close_next;
    logic             pend_end_reg,   pend_end_next;

    // Output register.
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg,  out_byte_next;
    logic       out_last_reg,  out_last_next;
    logic       out_trunc_reg, out_trunc_next;

    // Label RAM ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic accept;
    logic is_close;
    logic can_load;
    logic has_room;

    assign name_in.ready = (state_reg == ST_IDLE);
    assign accept        = name_in.valid && name_in.ready;
    assign is_close      = name_in.end_of_name || (name_in.name_char == DOT_CHAR);
    assign has_room      = (count_reg < CNT_W'(LABEL_MAX));
    // Load the output register when it is empty or its word leaves this cycle.
    assign can_load      = !out_valid_reg || pkt_out.ready;

    assign pkt_out.valid           = out_valid_reg;
    assign pkt_out.packet_byte     = out_byte_reg;
    assign pkt_out.last_byte       = out_last_reg;
    assign pkt_out.label_truncated = out_trunc_reg;

    // Characters go into the RAM at accept time; reads happen only while
    // emitting, when no word is accepted, so the two ports never collide.
    assign ram_we    = accept && !is_close && has_room;
    assign ram_waddr = count_reg[ADDR_W-1:0];

    dqne_ram #(
        .WIDTH (8),
        .DEPTH (LABEL_MAX)
    ) u_label_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (name_in.name_char),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        hdr_idx_next    = hdr_idx_reg;
        tail_idx_next   = tail_idx_reg;
        rd_idx_next     = rd_idx_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        started_next    = started_reg;
        pend_close_next = pend_close_reg;
        pend_end_next   = pend_end_reg;
        out_valid_next  = out_valid_reg && !pkt_out.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_trunc_next  = out_trunc_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_close_next = is_close;
                    pend_end_next   = name_in.end_of_name;
                    started_next    = 1'b1;
                    hdr_idx_next    = '0;
                    if (!is_close)
                    begin
                        if (has_room)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (!started_reg)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (is_close)
                    begin
                        state_next = ST_LEN;
                    end
                end
            end

            ST_HDR:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b0;
                    out_trunc_next = 1'b0;
                    case (hdr_idx_reg)
                        HDR_ID_HI:    out_byte_next = query_id_reg[15:8];
                        HDR_ID_LO:    out_byte_next = query_id_reg[7:0];
                        HDR_FLAGS_HI: out_byte_next = header_flags_reg[15:8];
                        HDR_FLAGS_LO: out_byte_next = header_flags_reg[7:0];
                        HDR_QDCNT_LO: out_byte_next = 8'd1;
                        default:      out_byte_next = 8'd0;
                    endcase
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                    if (hdr_idx_reg == HDR_LAST)
                    begin
                        state_next = pend_close_reg ? ST_LEN : ST_IDLE;
                    end
                end
            end

            ST_LEN:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'(count_reg);
                    out_last_next  = 1'b0;
                    out_trunc_next = overflow_reg;
                    rd_idx_next    = '0;
                    tail_idx_next  = '0;
                    if (count_reg != '0)
                    begin
                        // Fetch the first character from the RAM while the length byte is loaded.
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_DATA;
                    end
                    else
                    begin
                        overflow_next = 1'b0;
                        state_next    = pend_end_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end

            ST_DATA:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rdata;
                    out_last_next  = 1'b0;
                    out_trunc_next = overflow_reg;
                    if (rd_idx_reg + 1'b1 < count_reg)
                    begin
                        ram_re      = 1'b1;
                        ram_raddr   = ADDR_W'(rd_idx_reg + 1'b1);
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        count_next    = '0;
                        overflow_next = 1'b0;
                        state_next    = pend_end_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end

            ST_TAIL:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_trunc_next = 1'b0;
                    out_last_next  = (tail_idx_reg == TL_CLASS_LO);
                    case (tail_idx_reg)
                        TL_TYPE_HI:  out_byte_next = qtype_reg[15:8];
                        TL_TYPE_LO:  out_byte_next = qtype_reg[7:0];
                        TL_CLASS_HI: out_byte_next = qclass_reg[15:8];
                        TL_CLASS_LO: out_byte_next = qclass_reg[7:0];
                        default:     out_byte_next = 8'd0;
                    endcase
                    tail_idx_next = tail_idx_reg + 1'b1;
                    if (tail_idx_reg == TL_CLASS_LO)
                    begin
                        started_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            hdr_idx_reg    <= '0;
            tail_idx_reg   <= '0;
            rd_idx_reg     <= '0;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            started_reg    <= 1'b0;
            pend_close_reg <= 1'b0;
            pend_end_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hdr_idx_reg    <= hdr_idx_next;
            tail_idx_reg   <= tail_idx_next;
            rd_idx_reg     <= rd_idx_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            started_reg    <= started_next;
            pend_close_reg <= pend_close_next;
            pend_end_reg   <= pend_end_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Output payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_trunc_reg <= out_trunc_next;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_id_reg     <= RST_QUERY_ID;
            header_flags_reg <= RST_HEADER_FLAGS;
            qtype_reg        <= RST_QTYPE;
            qclass_reg       <= RST_QCLASS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUERY_ID:     query_id_reg     <= cfg_data;
                CFG_HEADER_FLAGS: header_flags_reg <= cfg_data;
                CFG_QTYPE:        qtype_reg        <= cfg_data;
                CFG_QCLASS:       qclass_reg       <= cfg_data;
                default:          ;
            endcase
        end
    end

endmodule
